### sv/dpda_pkg.sv
// ----------------------------------------------------------------------------
// dpda_pkg
// Shared types and constants for the daily, periodic and deadline alarms.
// ----------------------------------------------------------------------------
package dpda_pkg;

  localparam int unsigned SecW     = 32;
  localparam int unsigned TimeW    = SecW + 1;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned DateW    = 27;
  localparam int unsigned IntvW    = 9;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [HourW-1:0] HoursPerDay    = HourW'(24);
  localparam logic [MinW-1:0]  MinutesPerHour = MinW'(60);
  localparam logic [IntvW-1:0] MinInterval    = IntvW'(15);
  localparam logic [IntvW-1:0] MaxInterval    = IntvW'(360);
  localparam logic [SecW-1:0]  RepeatSeconds  = SecW'(300);

  localparam logic [HourW-1:0] DailyHourRst       = HourW'(8);
  localparam logic [MinW-1:0]  DailyMinuteRst     = MinW'(0);
  localparam logic [IntvW-1:0] PeriodicMinutesRst = IntvW'(60);

  typedef enum logic [IdxW-1:0] {
    REG_DAILY_ENABLE     = 3'd0,
    REG_DAILY_HOUR       = 3'd1,
    REG_DAILY_MINUTE     = 3'd2,
    REG_PERIODIC_ENABLE  = 3'd3,
    REG_PERIODIC_MINUTES = 3'd4,
    REG_DEADLINE_ARMED   = 3'd5,
    REG_DEADLINE_SECONDS = 3'd6
  } dpda_reg_e;

  typedef struct packed {
    logic [SecW-1:0]  now_seconds;
    logic [HourW-1:0] now_hour;
    logic [MinW-1:0]  now_minute;
    logic [DateW-1:0] date_key;
  } dpda_in_t;

  typedef struct packed {
    logic daily_fire;
    logic periodic_fire;
    logic deadline_fire;
  } dpda_out_t;

  // Current register settings
  typedef struct packed {
    logic             daily_enable;
    logic [HourW-1:0] daily_hour;
    logic [MinW-1:0]  daily_minute;
    logic             periodic_enable;
    logic [IntvW-1:0] periodic_minutes;
    logic             deadline_armed;
    logic [SecW-1:0]  deadline_seconds;
  } dpda_cfg_t;

  // Side effects of a register write on the alarm state
  typedef struct packed {
    logic            daily_clr;
    logic            periodic_clr;
    logic            repeat_ld;
    logic [SecW-1:0] repeat_val;
  } dpda_cfg_evt_t;

endpackage

### sv/dpda_cfg.sv
// ----------------------------------------------------------------------------
// dpda_cfg
// Register file: reduces, clamps and stores written settings, and flags the
// alarm state that a write resets.
// ----------------------------------------------------------------------------
module dpda_cfg
  import dpda_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output dpda_cfg_t           cfg_o,
  output dpda_cfg_evt_t       evt_o
);

  dpda_cfg_t       cfg_d, cfg_q;
  logic [HourW-1:0] hour_raw;
  logic [MinW-1:0]  min_raw;
  logic [IntvW-1:0] intv_raw;

  assign hour_raw = cfg_data_i[HourW-1:0];
  assign min_raw  = cfg_data_i[MinW-1:0];
  assign intv_raw = cfg_data_i[IntvW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    evt_o = '0;
    if (cfg_we_i) begin
      case (dpda_reg_e'(cfg_idx_i))
        REG_DAILY_ENABLE: begin
          cfg_d.daily_enable = cfg_data_i[0];
          evt_o.daily_clr    = 1'b1;
        end
        REG_DAILY_HOUR: begin
          cfg_d.daily_hour = (hour_raw >= HoursPerDay) ? hour_raw - HoursPerDay : hour_raw;
          evt_o.daily_clr  = 1'b1;
        end
        REG_DAILY_MINUTE: begin
          cfg_d.daily_minute = (min_raw >= MinutesPerHour) ? min_raw - MinutesPerHour
                                                           : min_raw;
          evt_o.daily_clr    = 1'b1;
        end
        REG_PERIODIC_ENABLE: begin
          cfg_d.periodic_enable = cfg_data_i[0];
          evt_o.periodic_clr    = 1'b1;
        end
        REG_PERIODIC_MINUTES: begin
          if (intv_raw < MinInterval) begin
            cfg_d.periodic_minutes = MinInterval;
          end else if (intv_raw > MaxInterval) begin
            cfg_d.periodic_minutes = MaxInterval;
          end else begin
            cfg_d.periodic_minutes = intv_raw;
          end
          evt_o.periodic_clr = 1'b1;
        end
        REG_DEADLINE_ARMED: begin
          if (cfg_data_i[0]) begin
            // arm only when a deadline is set
            if (cfg_q.deadline_seconds != '0) begin
              cfg_d.deadline_armed = 1'b1;
              evt_o.repeat_ld      = 1'b1;
              evt_o.repeat_val     = cfg_q.deadline_seconds;
            end
          end else begin
            // acknowledge: disarm and drop the deadline
            cfg_d.deadline_armed   = 1'b0;
            cfg_d.deadline_seconds = '0;
            evt_o.repeat_ld        = 1'b1;
            evt_o.repeat_val       = '0;
          end
        end
        REG_DEADLINE_SECONDS: begin
          cfg_d.deadline_seconds = cfg_data_i[SecW-1:0];
          evt_o.repeat_ld        = 1'b1;
          evt_o.repeat_val       = cfg_data_i[SecW-1:0];
          if (cfg_data_i[SecW-1:0] == '0) begin
            cfg_d.deadline_armed = 1'b0;
          end
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.daily_enable     <= 1'b0;
      cfg_q.daily_hour       <= DailyHourRst;
      cfg_q.daily_minute     <= DailyMinuteRst;
      cfg_q.periodic_enable  <= 1'b0;
      cfg_q.periodic_minutes <= PeriodicMinutesRst;
      cfg_q.deadline_armed   <= 1'b0;
      cfg_q.deadline_seconds <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/dpda_core.sv
// ----------------------------------------------------------------------------
// dpda_core
// Alarm state and per-tick evaluation: compares, one add each for the periodic
// and deadline alarms, and the state update on each accepted tick.
// ----------------------------------------------------------------------------
module dpda_core
  import dpda_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dpda_cfg_t     cfg_i,
  input  dpda_cfg_evt_t evt_i,
  input  logic          tick_i,
  input  dpda_in_t      tick_data_i,
  output dpda_out_t     fire_o
);

  logic [DateW-1:0] last_date_d, last_date_q;
  logic [TimeW-1:0] next_per_d, next_per_q;
  logic [TimeW-1:0] next_rep_d, next_rep_q;

  logic [TimeW-1:0] now;
  logic [14:0]      intv_sec;
  logic [TimeW-1:0] per_later;
  logic [TimeW-1:0] rep_later;
  logic             daily_hit, per_due, dl_hit;

  assign now       = {1'b0, tick_data_i.now_seconds};
  assign intv_sec  = 15'(cfg_i.periodic_minutes) * 15'd60;
  assign per_later = now + TimeW'(intv_sec);
  assign rep_later = now + TimeW'(RepeatSeconds);

  assign daily_hit = cfg_i.daily_enable
                   && (tick_data_i.now_hour == cfg_i.daily_hour)
                   && (tick_data_i.now_minute == cfg_i.daily_minute)
                   && (last_date_q != tick_data_i.date_key);
  assign per_due   = cfg_i.periodic_enable && (next_per_q != '0) && (now >= next_per_q);
  assign dl_hit    = cfg_i.deadline_armed
                   && (now >= {1'b0, cfg_i.deadline_seconds})
                   && (now >= next_rep_q);

  assign fire_o.daily_fire    = daily_hit;
  assign fire_o.periodic_fire = per_due;
  assign fire_o.deadline_fire = dl_hit;

  always_comb begin
    last_date_d = last_date_q;
    next_per_d  = next_per_q;
    next_rep_d  = next_rep_q;
    if (tick_i) begin
      if (daily_hit) begin
        last_date_d = tick_data_i.date_key;
      end
      if (!cfg_i.periodic_enable) begin
        next_per_d = '0;
      end else if ((next_per_q == '0) || per_due) begin
        next_per_d = per_later;
      end
      if (dl_hit) begin
        next_rep_d = rep_later;
      end
    end
    // register writes must arrive only while idle, which this block does not enforce; let them win
    if (evt_i.daily_clr) begin
      last_date_d = '0;
    end
    if (evt_i.periodic_clr) begin
      next_per_d = '0;
    end
    if (evt_i.repeat_ld) begin
      next_rep_d = {1'b0, evt_i.repeat_val};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_date_q <= '0;
      next_per_q  <= '0;
      next_rep_q  <= '0;
    end else begin
      last_date_q <= last_date_d;
      next_per_q  <= next_per_d;
      next_rep_q  <= next_rep_d;
    end
  end

endmodule

### sv/daily_periodic_deadline_alarms.sv
// Result valid is registered and rises in the cycle after the tick transfer.
// Throughput: one tick per cycle when results drain; the result register frees
// as it is taken, so input and output transfers can happen in the same cycle.
// Reset: asynchronous, active low; settings return to their defaults
// (daily 08:00, 60 minute interval, all alarms off) and alarm state clears.
// ----------------------------------------------------------------------------
// daily_periodic_deadline_alarms
// Top level: tick and result handshakes, register port, result register.
// ----------------------------------------------------------------------------
module daily_periodic_deadline_alarms
  import dpda_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dpda_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dpda_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [IdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dpda_cfg_t     cfg;
  dpda_cfg_evt_t evt;
  dpda_out_t     fire;
  dpda_out_t     out_data_q;
  logic          out_valid_d, out_valid_q;
  logic          tick;

  // accept when the result slot is empty or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign tick       = in_valid_i && in_ready_o;

  dpda_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .evt_o      (evt)
  );

  dpda_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .evt_i       (evt),
    .tick_i      (tick),
    .tick_data_i (in_data_i),
    .fire_o      (fire)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (tick) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_data_q <= fire;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the daily, periodic and deadline alarms.
// Ticks go in over a valid/ready channel and each transfer is run through a
// cycle-free alarm predictor; every result transfer is checked flag by flag
// against the oldest expected result. Settings change only while idle.
// ----------------------------------------------------------------------------
module tb;
  import dpda_pkg::*;

  localparam logic [IdxW-1:0] RegUnused    = 3'd7;
  localparam int unsigned     CycleLimit   = 400000;
  localparam int unsigned     PhaseCnt     = 12;
  localparam int unsigned     TicksPerPhase = 128;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  dpda_in_t            in_data_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  dpda_out_t           out_data_o;
  logic                cfg_we_i     = 1'b0;
  logic [IdxW-1:0]     cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;

  daily_periodic_deadline_alarms u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor state
  dpda_cfg_t        alarm_cfg;
  logic [DateW-1:0] last_daily_date;
  logic [TimeW-1:0] next_periodic_at;
  logic [TimeW-1:0] next_deadline_at;

  dpda_in_t  tick_q[$];
  dpda_out_t fire_q[$];

  int unsigned      send_idle_pct = 27;
  int unsigned      recv_idle_pct = 72;
  int unsigned      mismatch_cnt  = 0;
  int unsigned      cycle_cnt     = 0;
  logic [SecW-1:0]  wall_sec;
  logic [DateW-1:0] wall_date;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void alarm_reset();
    alarm_cfg                  = '0;
    alarm_cfg.daily_hour       = DailyHourRst;
    alarm_cfg.daily_minute     = DailyMinuteRst;
    alarm_cfg.periodic_minutes = PeriodicMinutesRst;
    last_daily_date            = '0;
    next_periodic_at           = '0;
    next_deadline_at           = '0;
  endfunction

  function automatic void alarm_write(logic [IdxW-1:0] idx, logic [CfgDataW-1:0] val);
    logic [IntvW-1:0] mins;
    case (idx)
      REG_DAILY_ENABLE: begin
        alarm_cfg.daily_enable = val[0];
        last_daily_date = '0;
      end
      REG_DAILY_HOUR: begin
        alarm_cfg.daily_hour = val[HourW-1:0] % HoursPerDay;
        last_daily_date = '0;
      end
      REG_DAILY_MINUTE: begin
        alarm_cfg.daily_minute = val[MinW-1:0] % MinutesPerHour;
        last_daily_date = '0;
      end
      REG_PERIODIC_ENABLE: begin
        alarm_cfg.periodic_enable = val[0];
        next_periodic_at = '0;
      end
      REG_PERIODIC_MINUTES: begin
        mins = val[IntvW-1:0];
        if (mins < MinInterval) mins = MinInterval;
        else if (mins > MaxInterval) mins = MaxInterval;
        alarm_cfg.periodic_minutes = mins;
        next_periodic_at = '0;
      end
      REG_DEADLINE_ARMED: begin
        if (val[0]) begin
          // arming without a deadline does nothing
          if (alarm_cfg.deadline_seconds != '0) begin
            alarm_cfg.deadline_armed = 1'b1;
            next_deadline_at = TimeW'(alarm_cfg.deadline_seconds);
          end
        end else begin
          alarm_cfg.deadline_armed   = 1'b0;
          alarm_cfg.deadline_seconds = '0;
          next_deadline_at           = '0;
        end
      end
      REG_DEADLINE_SECONDS: begin
        alarm_cfg.deadline_seconds = val[SecW-1:0];
        next_deadline_at = TimeW'(val[SecW-1:0]);
        if (val[SecW-1:0] == '0) alarm_cfg.deadline_armed = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic dpda_out_t alarm_step(dpda_in_t tick);
    dpda_out_t        fire;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] later;
    fire = '0;
    now  = TimeW'(tick.now_seconds);
    if (alarm_cfg.daily_enable && tick.now_hour == alarm_cfg.daily_hour &&
        tick.now_minute == alarm_cfg.daily_minute && last_daily_date != tick.date_key) begin
      last_daily_date = tick.date_key;
      fire.daily_fire = 1'b1;
    end
    if (alarm_cfg.periodic_enable) begin
      later = now + TimeW'(alarm_cfg.periodic_minutes) * TimeW'(60);
      if (next_periodic_at == '0) begin
        next_periodic_at = later;
      end else if (now >= next_periodic_at) begin
        fire.periodic_fire = 1'b1;
        next_periodic_at = later;
      end
    end else begin
      next_periodic_at = '0;
    end
    if (alarm_cfg.deadline_armed && now >= TimeW'(alarm_cfg.deadline_seconds) &&
        now >= next_deadline_at) begin
      fire.deadline_fire = 1'b1;
      next_deadline_at = now + TimeW'(RepeatSeconds);
    end
    return fire;
  endfunction

  function automatic void check_flag(string name, logic exp_v, logic got_v);
    if (got_v !== exp_v) begin
      mismatch_cnt++;
      $display("%0t mismatch %s: expected %0b actual %0b", $time, name, exp_v, got_v);
    end
  endfunction

  // Driver: predict on each tick transfer, then refill the slot
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) fire_q.push_back(alarm_step(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= tick_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    dpda_out_t exp_fire;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (fire_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t unexpected result: expected none actual %b", $time, out_data_o);
        end else begin
          exp_fire = fire_q.pop_front();
          check_flag("daily_fire", exp_fire.daily_fire, out_data_o.daily_fire);
          check_flag("periodic_fire", exp_fire.periodic_fire, out_data_o.periodic_fire);
          check_flag("deadline_fire", exp_fire.deadline_fire, out_data_o.deadline_fire);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || fire_q.size() != 0);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    alarm_write(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_tick(logic [SecW-1:0] sec, logic [HourW-1:0] hr,
                           logic [MinW-1:0] mn, logic [DateW-1:0] date);
    dpda_in_t tick;
    tick.now_seconds = sec;
    tick.now_hour    = hr;
    tick.now_minute  = mn;
    tick.date_key    = date;
    tick_q.push_back(tick);
  endtask

  function automatic logic [CfgDataW-1:0] setting_value(logic [IdxW-1:0] idx, int phase);
    logic [CfgDataW-1:0] val;
    val = $urandom;
    case (idx)
      REG_DAILY_ENABLE:    if ($urandom_range(4) != 0) val = 32'd1;
      REG_DAILY_HOUR: begin
        case (phase % 4)
          1: val = 32'd23;
          2: val = 32'd0;
          3: val = 32'($urandom_range(24, 31));
          default: ;
        endcase
      end
      REG_DAILY_MINUTE: begin
        case (phase % 4)
          1: val = 32'd59;
          2: val = 32'd0;
          3: val = 32'($urandom_range(60, 63));
          default: ;
        endcase
      end
      REG_PERIODIC_ENABLE: val = 32'($urandom_range(6) != 0);
      REG_PERIODIC_MINUTES: begin
        case (phase % 5)
          0: val = 32'd15;
          1: val = 32'd360;
          2: val = 32'($urandom_range(14));
          3: val = {val[31:9], 9'($urandom_range(361, 511))};
          default: val = 32'($urandom_range(15, 60));
        endcase
      end
      REG_DEADLINE_ARMED:  val = 32'($urandom_range(4) != 0);
      REG_DEADLINE_SECONDS: begin
        case ($urandom_range(19))
          0, 1: val = '0;
          2: val = '1;
          default: val = wall_sec + 32'($urandom_range(3000));
        endcase
      end
      default: ;
    endcase
    return val;
  endfunction

  task automatic phase_settings(int phase);
    for (int k = 0; k <= 6; k++) begin
      if (phase == 0 || $urandom_range(3) != 0)
        write_reg(IdxW'(k), setting_value(IdxW'(k), phase));
    end
    // arm again so that a fresh deadline usually counts
    if ($urandom_range(9) < 7) write_reg(REG_DEADLINE_ARMED, 32'd1);
    if (phase == 3) write_reg(RegUnused, $urandom);
    end_writes();
  endtask

  function automatic dpda_in_t make_tick();
    dpda_in_t    tick;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      tick.now_seconds = $urandom;
      tick.now_hour    = HourW'($urandom_range(31));
      tick.now_minute  = MinW'($urandom_range(63));
      tick.date_key    = DateW'($urandom);
      return tick;
    end
    if (pick < 8) wall_sec = wall_sec - 32'($urandom_range(5000));
    else if (pick < 12) wall_sec = wall_sec + 32'($urandom_range(100000));
    else wall_sec = wall_sec + 32'($urandom_range(1, 400));
    if ($urandom_range(9) == 0) wall_date = wall_date + DateW'(1);
    tick.now_seconds = wall_sec;
    tick.date_key    = wall_date;
    pick = $urandom_range(99);
    if (pick < 30) begin
      tick.now_hour   = alarm_cfg.daily_hour;
      tick.now_minute = alarm_cfg.daily_minute;
    end else if (pick < 34) begin
      tick.now_hour   = HourW'($urandom_range(24, 31));
      tick.now_minute = MinW'($urandom_range(60, 63));
    end else begin
      tick.now_hour   = HourW'($urandom_range(23));
      tick.now_minute = MinW'($urandom_range(59));
    end
    return tick;
  endfunction

  initial begin
    alarm_reset();
    wall_sec  = 32'($urandom_range(1000000));
    wall_date = DateW'(20240101);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: everything off
    push_tick(32'd0, 5'd8, 6'd0, 27'd0);
    push_tick(32'hFFFF_FFFF, 5'd8, 6'd0, 27'h7FF_FFFF);
    wait_idle();

    write_reg(REG_DAILY_ENABLE, 32'd1);
    write_reg(REG_DAILY_HOUR, 32'd23);
    write_reg(REG_DAILY_MINUTE, 32'd59);
    write_reg(REG_PERIODIC_ENABLE, 32'd1);
    write_reg(REG_PERIODIC_MINUTES, 32'd15);
    write_reg(REG_DEADLINE_SECONDS, 32'd1000);
    write_reg(REG_DEADLINE_ARMED, 32'd1);
    end_writes();
    push_tick(32'd0, 5'd23, 6'd59, 27'd0);          // date zero matches cleared date
    push_tick(32'd10, 5'd23, 6'd59, 27'd20240101);
    push_tick(32'd20, 5'd23, 6'd59, 27'd20240101);  // once per date
    push_tick(32'd30, 5'd31, 6'd59, 27'd20240102);
    push_tick(32'd40, 5'd23, 6'd63, 27'd20240102);
    push_tick(32'd50, 5'd24, 6'd59, 27'd20240102);
    push_tick(32'd899, 5'd23, 6'd59, 27'd20240102);
    push_tick(32'd900, 5'd0, 6'd0, 27'd20240102);
    push_tick(32'd1000, 5'd0, 6'd0, 27'd20240102);
    push_tick(32'd1299, 5'd0, 6'd0, 27'd20240102);
    push_tick(32'd1300, 5'd0, 6'd0, 27'd20240102);
    push_tick(32'd5, 5'd0, 6'd0, 27'd20240102);     // time going back
    push_tick(32'hFFFF_FFFF, 5'd23, 6'd59, 27'h7FF_FFFF);
    push_tick(32'hFFFF_FFFF, 5'd23, 6'd59, 27'h7FF_FFFF);
    wait_idle();

    write_reg(REG_PERIODIC_ENABLE, 32'd0);
    write_reg(REG_DEADLINE_SECONDS, 32'hFFFF_FFFF);
    write_reg(REG_DEADLINE_ARMED, 32'd1);
    end_writes();
    push_tick(32'hFFFF_FFFE, 5'd1, 6'd1, 27'd1);
    push_tick(32'hFFFF_FFFF, 5'd1, 6'd1, 27'd1);
    wait_idle();

    // acknowledge, then try to arm with no deadline
    write_reg(REG_DEADLINE_ARMED, 32'd0);
    write_reg(REG_DEADLINE_ARMED, 32'd1);
    end_writes();
    push_tick(32'hFFFF_FFFF, 5'd1, 6'd1, 27'd1);
    wait_idle();

    write_reg(REG_DEADLINE_SECONDS, 32'd7);
    write_reg(REG_DEADLINE_ARMED, 32'd1);
    write_reg(REG_DEADLINE_SECONDS, 32'd0);
    end_writes();
    push_tick(32'd100, 5'd1, 6'd1, 27'd1);
    wait_idle();

    for (int phase = 0; phase < PhaseCnt; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 27;
      end
      if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 10) wall_sec = 32'hFFFF_FFFF - 32'd30000;
      phase_settings(phase);
      for (int i = 0; i < TicksPerPhase; i++) begin
        tick_q.push_back(make_tick());
        // hold the sender until every result is back
        if (phase == 5 && i == TicksPerPhase / 2) wait_idle();
      end
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0 && fire_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
